// File: rtl/maf_pkg.sv
// shared constants for the moving average filter
package maf_pkg;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd11;

endpackage

// File: rtl/maf_stream_if.sv
// sample and average stream interfaces
interface maf_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface maf_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

// File: rtl/moving_average_filter_unit.sv
// top level of the streaming boxcar moving average filter
//
// i_in carries one signed sample and a restart flag per transfer; o_out carries
// one signed average per result. both use valid/ready, a transfer happening
// when both are high. i_cfg_we/i_cfg_data write the window length (0 acts as
// 1, values above MAX_WINDOW act as MAX_WINDOW); a write also clears the window
// and must only be made while the block is idle.
// no result is given until the window holds window-length samples since the
// last clear; after that every sample gives one average, truncated toward zero.
// the front end reads the delay line, then updates the sum, and takes no new
// sample before the sum update is done. the divider loads a job, works out
// one quotient bit per cycle (SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW)) and
// then writes the output register once it is free; it takes no new job before
// that, which sets the sustained rate.
// a two-entry job queue sits between front end and divider; when the receiver
// stalls, the output register holds, the divider finishes into a wait state,
// the queue fills and finally i_in.ready drops. nothing is lost.
// reset sets window length 11 and empties the window; delay line contents are
// not cleared and are never used before being written.
module moving_average_filter_unit #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [maf_pkg::CFG_W-1:0] i_cfg_data,
    maf_in_if.sink                    i_in,
    maf_out_if.source                 o_out
);
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int JOB_W = SUM_W + LEN_W;

    logic             q_push, q_full, q_pop, q_empty;
    logic [JOB_W-1:0] q_wdata, q_rdata;

    maf_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .LEN_W       (LEN_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    maf_queue #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    maf_divider #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .LEN_W       (LEN_W)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job_data  (q_rdata),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("job pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    a_front_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("front end ready in the cycle after a sample transfer");

endmodule

// File: rtl/maf_ram.sv
// generic single write port ram with registered read, read-first
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/maf_queue.sv
// small fifo of sum/length jobs between the window front end and the divider
module maf_queue #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// File: rtl/maf_front.sv
// window front end: delay line, running sum and fill count, issues divide jobs
module maf_front #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW),
    parameter int LEN_W       = $clog2(MAX_WINDOW + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [maf_pkg::CFG_W-1:0]   i_cfg_data,
    maf_in_if.sink                      i_in,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output logic [SUM_W+LEN_W-1:0]      o_q_data
);
    localparam int PTR_W = $clog2(MAX_WINDOW);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SUM
    } t_front_state;

    t_front_state                  r_state;
    logic [maf_pkg::CFG_W-1:0]     r_window_len;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic [LEN_W-1:0]              r_fill, n_fill;
    logic [PTR_W-1:0]              r_ptr, n_ptr;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_sub;

    logic [LEN_W-1:0]              len;
    logic                          accept;
    logic [LEN_W-1:0]              base_fill;
    logic [PTR_W-1:0]              base_ptr;
    logic [PTR_W:0]                ptr_x, len_x, wrap_x;
    logic [PTR_W-1:0]              oldest;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic signed [SUM_W-1:0]       old_ext, new_ext;
    logic                          produce;
    logic                          advance;

    always_comb begin
        if (r_window_len == '0) begin
            len = LEN_W'(1);
        end else if (32'(r_window_len) > 32'(MAX_WINDOW)) begin
            len = LEN_W'(MAX_WINDOW);
        end else begin
            len = LEN_W'(r_window_len);
        end
    end

    // no sample transfer in a cycle that writes the window length
    assign i_in.ready = (r_state == S_IDLE) && !i_cfg_we;
    assign accept     = i_in.valid && i_in.ready;

    // restart clears the window before the sample goes in
    assign base_fill = i_in.restart ? '0 : r_fill;
    assign base_ptr  = i_in.restart ? '0 : r_ptr;

    assign ptr_x  = {1'b0, base_ptr};
    assign len_x  = (PTR_W + 1)'(len);
    assign wrap_x = ptr_x + (PTR_W + 1)'(MAX_WINDOW) - len_x;
    assign oldest = PTR_W'((ptr_x >= len_x) ? ptr_x - len_x : wrap_x);

    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_delay_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (base_ptr),
        .i_wdata (i_in.sample),
        .i_re    (accept),
        .i_raddr (oldest),
        .o_rdata (rd_data)
    );

    assign old_ext = r_sub ? {{(SUM_W - SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data}
                           : '0;
    assign new_ext = {{(SUM_W - SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample};
    assign n_sum   = r_sum - old_ext + new_ext;
    assign n_fill  = (r_fill < len) ? r_fill + 1'b1 : r_fill;
    assign n_ptr   = (r_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_ptr + 1'b1;
    assign produce = (n_fill >= len);
    // hold the sum stage while it has a job to push and the job queue has no room
    assign advance = (r_state == S_SUM) && !(produce && i_q_full);

    assign o_q_push = advance && produce;
    assign o_q_data = {n_sum, len};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_in.sample;
            r_sub    <= (base_fill >= len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window_len <= maf_pkg::WINDOW_LEN_RESET;
            r_sum        <= '0;
            r_fill       <= '0;
            r_ptr        <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_window_len <= i_cfg_data;
                        r_sum        <= '0;
                        r_fill       <= '0;
                        r_ptr        <= '0;
                    end else if (accept) begin
                        if (i_in.restart) begin
                            r_sum  <= '0;
                            r_fill <= '0;
                            r_ptr  <= '0;
                        end
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (advance) begin
                        r_sum   <= n_sum;
                        r_fill  <= n_fill;
                        r_ptr   <= n_ptr;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/maf_divider.sv
// radix-2 restoring divider, truncates toward zero, drives the average output register
module maf_divider #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 22,
    parameter int LEN_W       = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_job_valid,
    input  logic [SUM_W+LEN_W-1:0]  i_job_data,
    output logic                    o_pop,
    maf_out_if.source               o_out
);
    localparam int CNT_W = $clog2(SUM_W);

    typedef enum logic [1:0] {
        D_IDLE,
        D_BUSY,
        D_FIN
    } t_div_state;

    t_div_state                    r_state;
    logic [SUM_W-1:0]              r_quo;
    logic [LEN_W-1:0]              r_rem;
    logic [LEN_W-1:0]              r_div;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_neg;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_avg;

    logic signed [SUM_W-1:0]       job_sum;
    logic [LEN_W-1:0]              job_len;
    logic [SUM_W-1:0]              job_mag;
    logic [LEN_W:0]                rem_sh, rem_sub;
    logic                          ge;
    logic [SAMPLE_BITS-1:0]        quo_s;
    logic                          out_free;

    assign job_sum = i_job_data[SUM_W+LEN_W-1:LEN_W];
    assign job_len = i_job_data[LEN_W-1:0];
    assign job_mag = job_sum[SUM_W-1] ? SUM_W'(-job_sum) : SUM_W'(job_sum);

    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    assign quo_s    = r_quo[SAMPLE_BITS-1:0];
    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = (r_state == D_IDLE) && i_job_valid;

    assign o_out.valid   = r_out_valid;
    assign o_out.average = r_out_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= D_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // the wait state drives valid on its own when it hands over
            if (r_out_valid && o_out.ready && r_state != D_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                D_IDLE: begin
                    if (i_job_valid) begin
                        r_quo   <= job_mag;
                        r_neg   <= job_sum[SUM_W-1];
                        r_div   <= job_len;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= D_BUSY;
                    end
                end
                D_BUSY: begin
                    r_rem <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SUM_W - 1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    if (out_free) begin
                        r_out_avg   <= r_neg ? -quo_s : quo_s;
                        r_out_valid <= 1'b1;
                        r_state     <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end
endmodule

// File: bench/tb_moving_average_filter_unit.sv
// self-checking testbench for the streaming boxcar moving average filter
`timescale 1ns / 1ps

module tb_moving_average_filter_unit;

    localparam int MAX_WIN       = 64;
    localparam int SMP_W         = 16;
    localparam int SUM_W         = 22;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int NUM_PHASES    = 13;
    localparam int PHASE_ITEMS   = 150;
    localparam int NUM_DIR       = 18;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [maf_pkg::CFG_W-1:0] win;
        logic signed [SMP_W-1:0]   smp;
        logic                      rs;
        int                        reps;
        logic                      typed;
        logic signed [SMP_W-1:0]   avg;
    } t_dir_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [maf_pkg::CFG_W-1:0] i_cfg_data;

    maf_in_if  #(.SAMPLE_BITS(SMP_W)) in_ch ();
    maf_out_if #(.SAMPLE_BITS(SMP_W)) out_ch ();

    moving_average_filter_unit #(
        .MAX_WINDOW (MAX_WIN),
        .SAMPLE_BITS(SMP_W)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    // mirror of the filter state
    logic [maf_pkg::CFG_W-1:0] win_reg;
    logic signed [SMP_W-1:0]   hist [MAX_WIN];
    logic signed [SUM_W-1:0]   acc_sum;
    logic [6:0]                fill_cnt;
    logic [5:0]                wr_ptr;

    logic signed [SMP_W-1:0]   avg_expect_q [$];
    int                        mismatch_count;
    int                        result_count;
    int                        quiet_cycles;
    bit                        gaps_on;
    bit                        stall_on;

    t_dir_row                  dir_rows [NUM_DIR];
    logic [maf_pkg::CFG_W-1:0] phase_wins [10];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [6:0] window_span(logic [maf_pkg::CFG_W-1:0] w);
        if (w == 0) return 7'd1;
        if (w > MAX_WIN) return 7'(MAX_WIN);
        return 7'(w);
    endfunction

    function void clear_window();
        acc_sum  = '0;
        fill_cnt = '0;
        wr_ptr   = '0;
    endfunction

    function void predict_average(input logic signed [SMP_W-1:0] s, input logic rs,
                                  output bit has_avg, output logic signed [SMP_W-1:0] avg);
        logic [6:0]              span;
        logic [5:0]              oldest;
        logic signed [SUM_W-1:0] quot;
        span = window_span(win_reg);
        if (rs) clear_window();
        // oldest slot is read before the write; same slot when the span is MAX_WIN
        if (fill_cnt >= span) begin
            oldest  = wr_ptr - span[5:0];
            acc_sum = acc_sum - hist[oldest];
        end
        acc_sum      = acc_sum + s;
        hist[wr_ptr] = s;
        wr_ptr       = wr_ptr + 6'd1;
        if (fill_cnt < span) fill_cnt = fill_cnt + 7'd1;
        has_avg = (fill_cnt >= span);
        quot    = acc_sum / $signed({15'd0, span});
        avg     = quot[SMP_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100) $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // drop valid, wait for every pending average, then let the pipeline empty
    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (avg_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_len(input logic [maf_pkg::CFG_W-1:0] w);
        drain_and_settle();
        i_cfg_data <= w;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_reg = w;
        clear_window();
    endtask

    task automatic send_sample(input logic signed [SMP_W-1:0] s, input logic rs,
                               input logic use_typed, input logic signed [SMP_W-1:0] typed_avg);
        bit                      has_avg;
        logic signed [SMP_W-1:0] avg;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= s;
        in_ch.restart <= rs;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        predict_average(s, rs, has_avg, avg);
        if (has_avg) avg_expect_q.push_back(use_typed ? typed_avg : avg);
    endtask

    // receiver: while stall_on is set, ready stalls in random bursts between open stretches
    initial begin
        int hold;
        out_ch.ready <= 1'b0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                hold = $urandom_range(0, 14);
            end else begin
                out_ch.ready <= 1'b1;
                hold = $urandom_range(0, 19);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_count++;
            if (avg_expect_q.size() == 0) begin
                report_mismatch($sformatf("average %0d with nothing expected", out_ch.average));
            end else if (out_ch.average !== avg_expect_q[0]) begin
                report_mismatch($sformatf("result %0d: average %0d, expected %0d",
                                          result_count, out_ch.average, avg_expect_q[0]));
                void'(avg_expect_q.pop_front());
            end else begin
                void'(avg_expect_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic signed [SMP_W-1:0] s;
        logic signed [SMP_W-1:0] run_val;
        int                      run_left;
        logic                    rs;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.sample  <= '0;
        in_ch.restart <= 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        quiet_cycles   = 0;
        gaps_on        = 1'b1;
        stall_on       = 1'b1;
        run_left       = 0;
        run_val        = '0;

        win_reg = maf_pkg::WINDOW_LEN_RESET;
        foreach (hist[i]) hist[i] = '0;
        clear_window();

        // kind, window, sample, restart, count, typed, average
        dir_rows = '{
            '{ROW_SAMPLE, 7'd0,   16'sd100,    1'b0, 11, 1'b1, 16'sd100},
            '{ROW_CFG,    7'd1,   16'sd0,      1'b0, 0,  1'b0, 16'sd0},
            '{ROW_SAMPLE, 7'd0,   16'sh7fff,   1'b0, 1,  1'b1, 16'sh7fff},
            '{ROW_SAMPLE, 7'd0,   16'sh8000,   1'b0, 1,  1'b1, 16'sh8000},
            '{ROW_SAMPLE, 7'd0,   16'sd0,      1'b1, 1,  1'b1, 16'sd0},
            '{ROW_SAMPLE, 7'd0,   -16'sd1,     1'b0, 1,  1'b1, -16'sd1},
            '{ROW_CFG,    7'd0,   16'sd0,      1'b0, 0,  1'b0, 16'sd0},
            '{ROW_SAMPLE, 7'd0,   16'sh5a5a,   1'b0, 1,  1'b1, 16'sh5a5a},
            '{ROW_CFG,    7'd2,   16'sd0,      1'b0, 0,  1'b0, 16'sd0},
            '{ROW_SAMPLE, 7'd0,   16'sd3,      1'b0, 1,  1'b0, 16'sd0},
            '{ROW_SAMPLE, 7'd0,   -16'sd4,     1'b0, 1,  1'b1, 16'sd0},
            '{ROW_SAMPLE, 7'd0,   -16'sd5,     1'b0, 1,  1'b1, -16'sd4},
            '{ROW_SAMPLE, 7'd0,   16'sd7,      1'b1, 1,  1'b0, 16'sd0},
            '{ROW_SAMPLE, 7'd0,   16'sd8,      1'b0, 1,  1'b1, 16'sd7},
            '{ROW_SAMPLE, 7'd0,   16'sh8000,   1'b0, 1,  1'b0, 16'sd0},
            '{ROW_CFG,    7'd3,   16'sd0,      1'b0, 0,  1'b0, 16'sd0},
            '{ROW_SAMPLE, 7'd0,   16'sh8000,   1'b0, 3,  1'b1, 16'sh8000},
            '{ROW_SAMPLE, 7'd0,   16'sh7fff,   1'b0, 1,  1'b0, 16'sd0}
        };
        phase_wins = '{7'd64, 7'd1, 7'd65, 7'd2, 7'd127, 7'd0, 7'd33, 7'd11, 7'd64, 7'd3};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_window_len(dir_rows[i].win);
            end else begin
                for (int k = 0; k < dir_rows[i].reps; k++)
                    send_sample(dir_rows[i].smp, dir_rows[i].rs && k == 0,
                                dir_rows[i].typed, dir_rows[i].avg);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // the closing phases run at full rate on both sides
            gaps_on  = (ph < NUM_PHASES - 2) && (ph % 3 != 1);
            stall_on = (ph < NUM_PHASES - 2) && (ph % 3 != 2);
            write_window_len(ph < 10 ? phase_wins[ph] : 7'($urandom_range(0, 127)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2) drain_and_settle();
                if (run_left > 0) begin
                    s = run_val;
                    run_left--;
                end else begin
                    case ($urandom_range(0, 9))
                        0: s = 16'sh7fff;
                        1: s = 16'sh8000;
                        2: s = SMP_W'($signed($urandom_range(0, 15)) - 8);
                        default: s = SMP_W'($urandom);
                    endcase
                    // long runs of one extreme push the sum to its limits
                    if ($urandom_range(0, 49) == 0) begin
                        run_left = $urandom_range(20, 80);
                        run_val  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    end
                end
                rs = ($urandom_range(0, 59) == 0);
                send_sample(s, rs, 1'b0, '0);
            end
        end

        drain_and_settle();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/maf_pkg.sv
rtl/maf_stream_if.sv
rtl/maf_ram.sv
rtl/maf_queue.sv
rtl/maf_front.sv
rtl/maf_divider.sv
rtl/moving_average_filter_unit.sv
bench/tb_moving_average_filter_unit.sv
